// ===== hw/rtl/pic_pkg.sv =====
`timescale 1ns / 1ps
// Package for the programmable interrupt controller: beat payload types,
// command, init-phase, OCW2 and OCW3 codes. No dependencies.
package pic_pkg;

	localparam int LINES_MAX = 8;
	localparam int LINE_W    = 3;

	typedef struct packed {
		logic [1:0]        cmd;
		logic              port;
		logic [7:0]        wdata;
		logic [LINE_W-1:0] irq_line;
	} pic_in_t;

	typedef struct packed {
		logic [7:0]        rdata;
		logic              ack_found;
		logic [LINE_W-1:0] ack_irq;
		logic [7:0]        vector_base;
	} pic_out_t;

	// item kinds
	localparam logic [1:0] CMD_WRITE   = 2'd0;
	localparam logic [1:0] CMD_READ    = 2'd1;
	localparam logic [1:0] CMD_REQUEST = 2'd2;
	localparam logic [1:0] CMD_ACK     = 2'd3;

	localparam logic PORT_CMD  = 1'b0;
	localparam logic PORT_DATA = 1'b1;

	// init sequence
	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_ICW2 = 2'd1;
	localparam logic [1:0] PH_ICW3 = 2'd2;
	localparam logic [1:0] PH_ICW4 = 2'd3;

	// OCW2 codes, bits 7..5
	localparam logic [2:0] OCW2_NS_EOI       = 3'd1;
	localparam logic [2:0] OCW2_SPEC_EOI     = 3'd3;
	localparam logic [2:0] OCW2_ROT_NS_EOI   = 3'd5;
	localparam logic [2:0] OCW2_SET_PRIO     = 3'd6;
	localparam logic [2:0] OCW2_ROT_SPEC_EOI = 3'd7;

	// OCW3 read-select field, bits 1..0
	localparam logic [1:0] OCW3_READ_IRR = 2'b10;
	localparam logic [1:0] OCW3_READ_ISR = 2'b11;

endpackage

// ===== hw/rtl/pic_stream_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel carrying one payload beat per handshake.
// Payload type is a parameter; used with the types of pic_pkg.
interface pic_stream_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/programmable_interrupt_controller_top.sv =====
`timescale 1ns / 1ps
// Channel   Dir  Payload                                   Handshake
// in_ch     in   cmd, port, wdata, irq_line (pic_in_t)     valid/ready
// out_ch    out  rdata, ack_found, ack_irq, vector_base    valid/ready
//
// One item per cycle sustained while the result is not stalled. Path: input register, then
// decode, rotating priority pick and register update into the result register.
// arst_n clears all controller state and both stage valids.
// A stalled result holds; the input register still takes a beat while the
// result register is free or being drained in the same cycle.
// Depends on pic_pkg and pic_stream_if.
module programmable_interrupt_controller_top
	import pic_pkg::*;
#(
	parameter int IRQ_LINES = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	pic_stream_if.sink             in_ch,
	pic_stream_if.source           out_ch
);

	localparam logic [3:0] LinesN    = 4'(IRQ_LINES);
	localparam logic [2:0] LastLine  = 3'(IRQ_LINES - 1);

	logic     valid_s1;
	pic_in_t  item_s1;
	logic     valid_s2;
	pic_out_t res_s2;
	logic     advance;

	logic [7:0] request_q, service_q, mask_q, base_q;
	logic       read_isr_q, expect_icw4_q, cascade_q;
	logic [1:0] phase_q;
	logic [2:0] top_q;

	logic [7:0] request_d, service_d, mask_d, base_d;
	logic       read_isr_d, expect_icw4_d, cascade_d;
	logic [1:0] phase_d;
	logic [2:0] top_d;
	pic_out_t   res_d;
	logic [3:0] req_pick, isr_pick;
	logic [2:0] ocw2_code, ocw2_line;

	// {found, line}: first set bit from top in rotating order
	function automatic logic [3:0] rot_pick(input logic [7:0] bits, input logic [2:0] top);
		logic [3:0] res;
		logic [3:0] idx;
		res = '0;
		for (int k = IRQ_LINES - 1; k >= 0; k--) begin
			idx = {1'b0, top} + 4'(k);
			if (idx >= LinesN) idx = idx - LinesN;
			if (bits[idx[2:0]]) res = {1'b1, idx[2:0]};
		end
		return res;
	endfunction

	function automatic logic [2:0] next_line(input logic [2:0] l);
		return (l == LastLine) ? 3'd0 : l + 3'd1;
	endfunction

	assign advance     = !valid_s2 || out_ch.ready;
	assign in_ch.ready = !valid_s1 || advance;
	assign out_ch.valid = valid_s2;
	assign out_ch.data  = res_s2;

	assign req_pick  = rot_pick(request_q, top_q);
	assign isr_pick  = rot_pick(service_q, top_q);
	assign ocw2_code = item_s1.wdata[7:5];
	assign ocw2_line = item_s1.wdata[2:0];

	always_comb begin
		request_d     = request_q;
		service_d     = service_q;
		mask_d        = mask_q;
		base_d        = base_q;
		read_isr_d    = read_isr_q;
		expect_icw4_d = expect_icw4_q;
		cascade_d     = cascade_q;
		phase_d       = phase_q;
		top_d         = top_q;
		res_d         = '0;
		case (item_s1.cmd)
			CMD_WRITE: begin
				if (item_s1.port == PORT_CMD) begin
					if (item_s1.wdata[4]) begin
						// ICW1
						expect_icw4_d = item_s1.wdata[0];
						cascade_d     = !item_s1.wdata[1];
						phase_d       = PH_ICW2;
					end else if (!item_s1.wdata[3]) begin
						// OCW2
						if (ocw2_code == OCW2_NS_EOI || ocw2_code == OCW2_ROT_NS_EOI) begin
							if (isr_pick[3]) begin
								service_d[isr_pick[2:0]] = 1'b0;
								if (ocw2_code == OCW2_ROT_NS_EOI)
									top_d = next_line(isr_pick[2:0]);
							end
						end else if ({1'b0, ocw2_line} < LinesN) begin
							if (ocw2_code == OCW2_SPEC_EOI || ocw2_code == OCW2_ROT_SPEC_EOI)
								service_d[ocw2_line] = 1'b0;
							if (ocw2_code == OCW2_SET_PRIO || ocw2_code == OCW2_ROT_SPEC_EOI)
								top_d = next_line(ocw2_line);
						end
					end else begin
						// OCW3: only the read select is honoured
						if (item_s1.wdata[1:0] == OCW3_READ_IRR) read_isr_d = 1'b0;
						else if (item_s1.wdata[1:0] == OCW3_READ_ISR) read_isr_d = 1'b1;
					end
				end else begin
					unique case (phase_q)
						PH_IDLE: mask_d = item_s1.wdata;
						PH_ICW2: begin
							base_d = item_s1.wdata;
							if (cascade_q) phase_d = PH_ICW3;
							else if (expect_icw4_q) phase_d = PH_ICW4;
							else phase_d = PH_IDLE;
						end
						PH_ICW3: phase_d = expect_icw4_q ? PH_ICW4 : PH_IDLE;
						default: phase_d = PH_IDLE;
					endcase
				end
			end
			CMD_READ: begin
				if (item_s1.port == PORT_CMD)
					res_d.rdata = read_isr_q ? service_q : request_q;
				else
					res_d.rdata = mask_q;
			end
			CMD_REQUEST: begin
				if ({1'b0, item_s1.irq_line} < LinesN && !mask_q[item_s1.irq_line])
					request_d[item_s1.irq_line] = 1'b1;
			end
			default: begin
				res_d.vector_base = base_q;
				if (req_pick[3]) begin
					request_d[req_pick[2:0]] = 1'b0;
					service_d[req_pick[2:0]] = 1'b1;
					res_d.ack_found          = 1'b1;
					res_d.ack_irq            = req_pick[2:0];
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1      <= 1'b0;
			valid_s2      <= 1'b0;
			request_q     <= '0;
			service_q     <= '0;
			mask_q        <= '0;
			base_q        <= '0;
			read_isr_q    <= 1'b0;
			expect_icw4_q <= 1'b0;
			cascade_q     <= 1'b0;
			phase_q       <= PH_IDLE;
			top_q         <= '0;
		end else begin
			if (in_ch.ready) valid_s1 <= in_ch.valid;
			if (advance) valid_s2 <= valid_s1;
			// state moves only when the item leaves the input register
			if (advance && valid_s1) begin
				request_q     <= request_d;
				service_q     <= service_d;
				mask_q        <= mask_d;
				base_q        <= base_d;
				read_isr_q    <= read_isr_d;
				expect_icw4_q <= expect_icw4_d;
				cascade_q     <= cascade_d;
				phase_q       <= phase_d;
				top_q         <= top_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) item_s1 <= in_ch.data;
		if (advance && valid_s1) res_s2 <= res_d;
	end

endmodule

// ===== hw/rtl/pic_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the interrupt controller, bound to its top level.
// Depends on pic_pkg and programmable_interrupt_controller_top.
module pic_checker
	import pic_pkg::*;
(
	input logic     clk,
	input logic     arst_n,
	input logic     in_ready,
	input logic     out_valid,
	input logic     out_ready,
	input pic_out_t out_data
);

	// a stalled result beat stays up
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result beat dropped while stalled");

	// and keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_data))
		else $error("result payload changed while stalled");

	// with the result register empty the input side must take a beat
	a_in_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty result register");

	a_ack_line: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.ack_found |-> out_data.ack_irq == '0)
		else $error("line reported without an acknowledge hit");

	a_ack_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.ack_found |-> out_data.rdata == '0)
		else $error("read data on an acknowledge beat");

endmodule

bind programmable_interrupt_controller_top pic_checker u_pic_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_data  (out_ch.data)
);
